>>> hdl/bim_pkg.sv
// Shared types, constants and helpers for the broadcast index mapper.
`default_nettype none
package bim_pkg;

    // Tensor geometry
    localparam int RANK       = 4;
    localparam int DIMS       = 4;
    localparam int DIM_W      = 16;
    localparam int IDX_W      = 32;
    localparam int STRIDE_W   = 32;
    localparam int OFFSET_W   = 50;
    localparam int PROD_W     = DIM_W + STRIDE_W;
    localparam int CFG_W      = 64;
    localparam int SPLIT_STEPS  = IDX_W;
    localparam int REDUCE_STEPS = DIM_W;
    localparam int ACTIVE_FIRST = (RANK > DIMS) ? 0 : ((RANK < 1) ? DIMS - 1 : DIMS - RANK);

    // Configuration register indexes
    localparam logic [1:0] REG_OUT_DIMS      = 2'd0;
    localparam logic [1:0] REG_IN_DIMS       = 2'd1;
    localparam logic [1:0] REG_STRIDES_OUTER = 2'd2;
    localparam logic [1:0] REG_STRIDES_INNER = 2'd3;
    localparam logic [63:0] DIMS_RESET       = 64'h0001_0001_0001_0001;

    // Data moved between neighboring divider cells
    typedef struct packed {
        logic                   valid;
        logic [DIM_W-1:0]       rem;
        logic [IDX_W-1:0]       work;
        logic [DIMS*DIM_W-1:0]  coords;
    } cell_t;

    // Effective size of dimension d; zero and padded dimensions count as 1
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] packed_dims,
                                                 input int d);
        logic [DIM_W-1:0] v;
        v = packed_dims[DIM_W*(DIMS-1-d) +: DIM_W];
        if (d < ACTIVE_FIRST || v == '0)
            return DIM_W'(1);
        return v;
    endfunction

endpackage
`default_nettype wire

>>> hdl/bim_div_cell.sv
// One restoring division step with its pipeline register.
`default_nettype none
module bim_div_cell
    import bim_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [DIM_W-1:0] divisor,
    input  wire cell_t            cell_in,
    output cell_t                 cell_out
);
    logic             valid_reg;
    logic [DIM_W-1:0] rem_reg;
    logic [IDX_W-1:0] work_reg;
    logic [DIMS*DIM_W-1:0] coords_reg;

    logic [DIM_W:0]   trial;
    logic             ge;
    logic [DIM_W-1:0] rem_next;
    logic [IDX_W-1:0] work_next;

    // Shift next dividend bit into the remainder, subtract if it fits
    always_comb
    begin
        trial     = {cell_in.rem, cell_in.work[IDX_W-1]};
        ge        = (trial >= {1'b0, divisor});
        rem_next  = ge ? DIM_W'(trial - {1'b0, divisor}) : trial[DIM_W-1:0];
        work_next = {cell_in.work[IDX_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= cell_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg    <= rem_next;
            work_reg   <= work_next;
            coords_reg <= cell_in.coords;
        end
    end

    assign cell_out = '{valid: valid_reg, rem: rem_reg, work: work_reg, coords: coords_reg};
endmodule
`default_nettype wire

>>> hdl/bim_offset_sum.sv
// Stride weighting and offset sum: multiply stage, then a two-level adder tree.
`default_nettype none
module bim_offset_sum
    import bim_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_vld,
    input  wire logic [DIMS*DIM_W-1:0] in_coords,
    input  wire logic [DIMS*DIM_W-1:0] in_reduced,
    input  wire logic [CFG_W-1:0]      strides_outer,
    input  wire logic [CFG_W-1:0]      strides_inner,
    output logic                       sum_vld,
    output logic [DIMS*DIM_W-1:0]      sum_coords,
    output logic [OFFSET_W-1:0]        sum_offset
);
    logic [STRIDE_W-1:0] stride [DIMS];
    logic [PROD_W-1:0]   prod_reg [DIMS];
    logic [PROD_W:0]     pair_reg [2];
    logic [OFFSET_W-1:0] sum_reg;
    logic [2:0]          vld_reg;
    logic [DIMS*DIM_W-1:0] coords_reg [3];

    assign stride[0] = strides_outer[63:32];
    assign stride[1] = strides_outer[31:0];
    assign stride[2] = strides_inner[63:32];
    assign stride[3] = strides_inner[31:0];

    // Valid bits of the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage 1: one 16x32 product per dimension
            for (int d = 0; d < DIMS; d++)
                prod_reg[d] <= PROD_W'(in_reduced[DIM_W*(DIMS-1-d) +: DIM_W])
                               * PROD_W'(stride[d]);
            // Stage 2: pair sums
            pair_reg[0] <= {1'b0, prod_reg[0]} + {1'b0, prod_reg[1]};
            pair_reg[1] <= {1'b0, prod_reg[2]} + {1'b0, prod_reg[3]};
            // Stage 3: final sum
            sum_reg <= {1'b0, pair_reg[0]} + {1'b0, pair_reg[1]};
            coords_reg[0] <= in_coords;
            coords_reg[1] <= coords_reg[0];
            coords_reg[2] <= coords_reg[1];
        end
    end

    assign sum_vld    = vld_reg[2];
    assign sum_coords = coords_reg[2];
    assign sum_offset = sum_reg;
endmodule
`default_nettype wire

>>> hdl/broadcast_index_mapper_top.sv
// Pipeline: 128 split cells, 16 reduce cells, 3 offset stages and an output
// register; it holds while the skid entry is full. Throughput: one item per
// cycle while the skid entry is empty; a two-entry output stage keeps accepting
// while one result waits. Reset: asynchronous, active low; clears valid bits,
// output flags and loads dims to 1 and strides to 0.
`default_nettype none
module broadcast_index_mapper_top
    import bim_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [IDX_W-1:0]    linear_index,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [DIM_W-1:0]         coord_outer,
    output logic [DIM_W-1:0]         coord_second,
    output logic [DIM_W-1:0]         coord_third,
    output logic [DIM_W-1:0]         coord_inner,
    output logic [OFFSET_W-1:0]      source_offset
);
    localparam int NSPLIT = DIMS * SPLIT_STEPS;

    logic [CFG_W-1:0] out_dims_reg, in_dims_reg, strides_outer_reg, strides_inner_reg;
    logic             en;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_dims_reg      <= DIMS_RESET;
            in_dims_reg       <= DIMS_RESET;
            strides_outer_reg <= '0;
            strides_inner_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OUT_DIMS:      out_dims_reg      <= cfg_data;
                REG_IN_DIMS:       in_dims_reg       <= cfg_data;
                REG_STRIDES_OUTER: strides_outer_reg <= cfg_data;
                REG_STRIDES_INNER: strides_inner_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Split chain: 32 cells per dimension, innermost first
    cell_t split_in  [NSPLIT];
    cell_t split_out [NSPLIT];

    genvar gi;
    generate
        for (gi = 0; gi < NSPLIT; gi++)
        begin : g_split
            localparam int DIM  = DIMS - 1 - gi / SPLIT_STEPS;
            if (gi == 0)
            begin : g_head
                assign split_in[gi] = '{valid: in_valid & en, rem: '0,
                                        work: linear_index, coords: '0};
            end
            else if (gi % SPLIT_STEPS == 0)
            begin : g_join
                // Finished dimension: park remainder, restart with quotient
                always_comb
                begin
                    split_in[gi]        = split_out[gi-1];
                    split_in[gi].rem    = '0;
                    split_in[gi].coords[DIM_W*(DIMS-2-DIM) +: DIM_W] = split_out[gi-1].rem;
                end
            end
            else
            begin : g_link
                assign split_in[gi] = split_out[gi-1];
            end
            bim_div_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .divisor (eff_dim(out_dims_reg, DIM)),
                .cell_in (split_in[gi]),
                .cell_out(split_out[gi])
            );
        end
    endgenerate

    // All coordinates after the split
    logic [DIMS*DIM_W-1:0] coords_all;
    always_comb
    begin
        coords_all = split_out[NSPLIT-1].coords;
        coords_all[DIM_W*(DIMS-1) +: DIM_W] = split_out[NSPLIT-1].rem;
    end

    // Reduce lanes: coordinate mod input dimension, 16 cells each
    cell_t red_in  [DIMS][REDUCE_STEPS];
    cell_t red_out [DIMS][REDUCE_STEPS];
    logic [DIMS*DIM_W-1:0] reduced;

    genvar gd, gs;
    generate
        for (gd = 0; gd < DIMS; gd++)
        begin : g_lane
            for (gs = 0; gs < REDUCE_STEPS; gs++)
            begin : g_step
                if (gs == 0)
                begin : g_head
                    assign red_in[gd][gs] = '{valid: split_out[NSPLIT-1].valid, rem: '0,
                        work: {coords_all[DIM_W*(DIMS-1-gd) +: DIM_W], {(IDX_W-DIM_W){1'b0}}},
                        coords: coords_all};
                end
                else
                begin : g_link
                    assign red_in[gd][gs] = red_out[gd][gs-1];
                end
                bim_div_cell u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .en      (en),
                    .divisor (eff_dim(in_dims_reg, gd)),
                    .cell_in (red_in[gd][gs]),
                    .cell_out(red_out[gd][gs])
                );
            end
            assign reduced[DIM_W*(DIMS-1-gd) +: DIM_W] = red_out[gd][REDUCE_STEPS-1].rem;
        end
    endgenerate

    logic                  sum_vld;
    logic [DIMS*DIM_W-1:0] sum_coords;
    logic [OFFSET_W-1:0]   sum_offset;

    bim_offset_sum u_sum (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_vld       (red_out[0][REDUCE_STEPS-1].valid),
        .in_coords    (red_out[0][REDUCE_STEPS-1].coords),
        .in_reduced   (reduced),
        .strides_outer(strides_outer_reg),
        .strides_inner(strides_inner_reg),
        .sum_vld      (sum_vld),
        .sum_coords   (sum_coords),
        .sum_offset   (sum_offset)
    );

    // Output register plus skid entry
    logic                  out_valid_reg, skid_valid_reg;
    logic [DIMS*DIM_W-1:0] out_coords_reg, skid_coords_reg;
    logic [OFFSET_W-1:0]   out_offset_reg, skid_offset_reg;

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
                skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
            out_valid_reg <= sum_vld;
        else if (sum_vld)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                out_coords_reg <= skid_coords_reg;
                out_offset_reg <= skid_offset_reg;
            end
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_coords_reg <= sum_coords;
            out_offset_reg <= sum_offset;
        end
        else
        begin
            skid_coords_reg <= sum_coords;
            skid_offset_reg <= sum_offset;
        end
    end

    assign out_valid     = out_valid_reg;
    assign coord_outer   = out_coords_reg[63:48];
    assign coord_second  = out_coords_reg[47:32];
    assign coord_third   = out_coords_reg[31:16];
    assign coord_inner   = out_coords_reg[15:0];
    assign source_offset = out_offset_reg;

    // Skid entry only ever backs up a waiting output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds data while output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready && sum_vld))
        else $error("skid entry filled without a stalled output");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> out_valid_reg && !skid_valid_reg)
        else $error("skid entry did not move into the output register");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(sum_offset) && $stable(sum_vld))
        else $error("pipeline moved while skid entry was full");
endmodule
`default_nettype wire
